// ===== hw/rtl/mlp_pkg.sv =====
// Package: constants, types and the tanh table of the three-layer perceptron.
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

	// Network shape and number formats.
	localparam int VecWidth     = 4;
	localparam int LayerCount   = 3;
	localparam int TanhEntries  = 256;
	localparam int TanhIdxBits  = $clog2(TanhEntries);
	localparam int TanhDoublings = 12;
	localparam int AccWidth     = 35;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_LOAD_WEIGHT = 2'd0,
		OP_LOAD_BIAS   = 2'd1,
		OP_INFER       = 2'd2,
		OP_UNUSED      = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_FIN,
		ST_OUT
	} ctl_state_t;

	// Store write sent to one cell.
	typedef struct packed {
		logic               we_weight;
		logic               we_bias;
		logic [1:0]         layer;
		logic [1:0]         col;
		logic signed [15:0] value;
	} cell_wr_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic       load_x;
		logic       mac;
		logic       fin;
		logic       last;
		logic [1:0] step;
		logic [1:0] layer;
	} cell_ctl_t;

	typedef logic [12:0] tanh_rom_t [TanhEntries];

	// Restoring division used only while the table is built.
	function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Each entry is tanh at the bin midpoint: series start, then repeated doublings in Q30.
	function automatic tanh_rom_t tanh_build();
		tanh_rom_t   rom;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] y3;
		logic [63:0] t;
		logic [63:0] t2;
		for (int k = 0; k < TanhEntries; k++) begin
			x  = (64'(2 * k + 1) << 31) / TanhEntries;
			y  = x >> TanhDoublings;
			y2 = (y * y) >> 30;
			y3 = (y2 * y) >> 30;
			t  = y - y3 / 3;
			for (int i = 0; i < TanhDoublings; i++) begin
				t2 = (t * t) >> 30;
				t  = div64(t << 31, (64'd1 << 30) + t2);
			end
			rom[k] = 13'((t + (64'd1 << 17)) >> 18);
		end
		return rom;
	endfunction

	localparam tanh_rom_t TanhRom = tanh_build();

endpackage
`default_nettype wire

// ===== hw/rtl/mlp_if.sv =====
// Interfaces: request and result channels of the perceptron.
`timescale 1ns / 1ps
`default_nettype none
interface mlp_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [1:0]         layer;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [15:0] value;
	logic signed [15:0] x0;
	logic signed [15:0] x1;
	logic signed [15:0] x2;
	logic signed [15:0] x3;
	modport source(output valid, operation, layer, row, col, value, x0, x1, x2, x3,
		input ready);
	modport sink(input valid, operation, layer, row, col, value, x0, x1, x2, x3,
		output ready);
endinterface

interface mlp_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] y0;
	logic signed [15:0] y1;
	logic signed [15:0] y2;
	logic signed [15:0] y3;
	logic               saturated;
	modport source(output valid, y0, y1, y2, y3, saturated, input ready);
	modport sink(input valid, y0, y1, y2, y3, saturated, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlp_cell.sv =====
// One neuron cell: its weight row and biases, a MAC, rounding, tanh and a ring stage.
`timescale 1ns / 1ps
`default_nettype none
module mlp_cell #(
	parameter int Idx = 0
) (
	input  wire                   clk,
	input  mlp_pkg::cell_wr_t     wr,
	input  mlp_pkg::cell_ctl_t    ctl,
	input  wire logic signed [15:0] x_in,
	input  wire logic signed [15:0] ring_in,
	output logic signed [15:0]    ring_out,
	output logic                  sat
);
	// Weight row of this neuron for every layer, addressed {layer, col}.
	logic signed [15:0] weight_q [mlp_pkg::LayerCount * mlp_pkg::VecWidth];
	logic signed [15:0] bias_q [mlp_pkg::LayerCount];
	logic signed [15:0] vec_q;
	logic signed [mlp_pkg::AccWidth-1:0] acc_q;

	logic [1:0]                          col;
	logic signed [15:0]                  w;
	logic signed [31:0]                  prod;
	logic signed [mlp_pkg::AccWidth-1:0] base;
	logic signed [35:0]                  rnd;
	logic signed [23:0]                  q;
	logic signed [15:0]                  clip;
	logic                                neg;
	logic [16:0]                         mag;
	logic [12:0]                         tv;
	logic signed [15:0]                  th;
	logic signed [15:0]                  res;

	// Store writes.
	always_ff @(posedge clk) begin
		if (wr.we_weight) begin
			weight_q[{wr.layer, wr.col}] <= wr.value;
		end
		if (wr.we_bias) begin
			bias_q[wr.layer] <= wr.value;
		end
	end

	// The vector rotates one cell per step, so this cell sees element Idx - step.
	always_comb begin
		col  = 2'(Idx) - ctl.step;
		w    = weight_q[{ctl.layer, col}];
		prod = 32'(w) * 32'(vec_q);
		base = (ctl.step == 2'd0) ?
			(mlp_pkg::AccWidth'(bias_q[ctl.layer]) <<< 12) : acc_q;
	end

	// Round half up, saturate, then tanh unless this is the last layer.
	always_comb begin
		rnd  = 36'(acc_q) + 36'sd2048;
		q    = 24'(rnd >>> 12);
		sat  = 1'b0;
		clip = q[15:0];
		if (q > 24'sd32767) begin
			clip = 16'sd32767;
			sat  = 1'b1;
		end else if (q < -24'sd32768) begin
			clip = -16'sd32768;
			sat  = 1'b1;
		end
		neg = clip[15];
		mag = neg ? -{clip[15], clip} : {clip[15], clip};
		tv  = (mag >= 17'd16384) ? 13'd4096 : mlp_pkg::TanhRom[mag[13 -: mlp_pkg::TanhIdxBits]];
		th  = neg ? -16'(tv) : 16'(tv);
		res = ctl.last ? clip : th;
	end

	// Accumulator and ring register.
	always_ff @(posedge clk) begin
		if (ctl.mac) begin
			acc_q <= base + mlp_pkg::AccWidth'(prod);
		end
		if (ctl.load_x) begin
			vec_q <= x_in;
		end else if (ctl.mac) begin
			vec_q <= ring_in;
		end else if (ctl.fin) begin
			vec_q <= res;
		end
	end

	assign ring_out = vec_q;
endmodule
`default_nettype wire

// ===== hw/rtl/mlp_three_layer_tanh_inference.sv =====
// Top level: sequencer, ring of four neuron cells and the result register.
//
//   channel   modport   carries
//   request   sink      operation, layer, row, col, value, x0..x3
//   result    source    y0..y3, saturated
//
// Loads are taken back to back while idle.
// An inference runs 3 layers, each of 4 ring MAC steps and one finish step; the output
// state then loads the result register, waiting while an earlier result is stalled.
// The ring of cells with one multiplier per cell sets the number of MAC steps.
// Reset clears the sequencer and result valid; the stores stay undefined.
// A stalled result holds; loads are still taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module mlp_three_layer_tanh_inference (
	input  wire       clk,
	input  wire       arst_n,
	mlp_req_if.sink   request,
	mlp_rsp_if.source result
);
	localparam int Vw = mlp_pkg::VecWidth;

	mlp_pkg::ctl_state_t state_q, state_d;
	logic [1:0]          step_q;
	logic [1:0]          layer_q;
	logic                sat_q;
	logic                out_valid_q;
	logic                out_sat_q;
	logic signed [15:0]  y_q [Vw];

	logic                accept;
	logic                start;
	logic                load_out;
	mlp_pkg::cell_ctl_t  ctl;
	mlp_pkg::cell_wr_t   wr [Vw];
	logic signed [15:0]  x_vec [Vw];
	logic signed [15:0]  ring [Vw];
	logic [Vw-1:0]       cell_sat;

	assign accept = request.valid && request.ready;
	assign start  = accept && (request.operation == mlp_pkg::OP_INFER);
	assign x_vec[0] = request.x0;
	assign x_vec[1] = request.x1;
	assign x_vec[2] = request.x2;
	assign x_vec[3] = request.x3;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlp_pkg::ST_IDLE: if (start) state_d = mlp_pkg::ST_MAC;
			mlp_pkg::ST_MAC: if (step_q == 2'(Vw - 1)) state_d = mlp_pkg::ST_FIN;
			mlp_pkg::ST_FIN: begin
				state_d = (layer_q == 2'(mlp_pkg::LayerCount - 1)) ?
					mlp_pkg::ST_OUT : mlp_pkg::ST_MAC;
			end
			mlp_pkg::ST_OUT: if (!out_valid_q || result.ready) state_d = mlp_pkg::ST_IDLE;
			default: state_d = mlp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		request.ready = (state_q == mlp_pkg::ST_IDLE);
		load_out      = (state_q == mlp_pkg::ST_OUT) && (!out_valid_q || result.ready);
		ctl.load_x    = start;
		ctl.mac       = (state_q == mlp_pkg::ST_MAC);
		ctl.fin       = (state_q == mlp_pkg::ST_FIN);
		ctl.last      = (layer_q == 2'(mlp_pkg::LayerCount - 1));
		ctl.step      = step_q;
		ctl.layer     = layer_q;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlp_pkg::ST_IDLE;
			step_q  <= '0;
			layer_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q  <= '0;
				layer_q <= '0;
				sat_q   <= 1'b0;
			end else if (ctl.mac) begin
				step_q <= step_q + 2'd1;
			end else if (ctl.fin) begin
				sat_q <= sat_q | (|cell_sat);
				if (!ctl.last) begin
					layer_q <= layer_q + 2'd1;
				end
			end
		end
	end

	// Ring of cells; each takes its neighbor's vector element every MAC step.
	for (genvar r = 0; r < Vw; r++) begin : g_cell
		always_comb begin
			wr[r].we_weight = accept && (request.operation == mlp_pkg::OP_LOAD_WEIGHT) &&
				(request.layer < 2'(mlp_pkg::LayerCount)) && (request.row == 2'(r));
			wr[r].we_bias   = accept && (request.operation == mlp_pkg::OP_LOAD_BIAS) &&
				(request.layer < 2'(mlp_pkg::LayerCount)) && (request.row == 2'(r));
			wr[r].layer     = request.layer;
			wr[r].col       = request.col;
			wr[r].value     = request.value;
		end
		mlp_cell #(.Idx(r)) u_cell (
			.clk     (clk),
			.wr      (wr[r]),
			.ctl     (ctl),
			.x_in    (x_vec[r]),
			.ring_in (ring[(r + Vw - 1) % Vw]),
			.ring_out(ring[r]),
			.sat     (cell_sat[r])
		);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sat_q <= sat_q;
			for (int r = 0; r < Vw; r++) begin
				y_q[r] <= ring[r];
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.y0        = y_q[0];
	assign result.y1        = y_q[1];
	assign result.y2        = y_q[2];
	assign result.y3        = y_q[3];
	assign result.saturated = out_sat_q;
endmodule
`default_nettype wire

// ===== hw/rtl/mlp_checker.sv =====
// Checker: port-level properties of the perceptron, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mlp_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire [1:0]        in_op,
	input wire              out_valid,
	input wire              out_ready,
	input wire signed [15:0] out_y0
);
	// An inference request makes the block busy on the next cycle.
	a_busy_after_infer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == mlp_pkg::OP_INFER) |=> !in_ready)
		else $error("block took a request right after an inference");

	// A load request leaves the block ready.
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_op == mlp_pkg::OP_LOAD_WEIGHT ||
		in_op == mlp_pkg::OP_LOAD_BIAS)) |=> in_ready)
		else $error("block went busy after a load");

	// A result is not shown in the cycle after a new inference is taken, if none was shown then.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_op == mlp_pkg::OP_INFER && !out_valid) |=> !out_valid)
		else $error("result appeared too early");

	// A stalled result stays valid and its y0 holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_y0)))
		else $error("stalled result changed");
endmodule

bind mlp_three_layer_tanh_inference mlp_checker u_mlp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (request.valid),
	.in_ready (request.ready),
	.in_op    (request.operation),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_y0   (result.y0)
);
`default_nettype wire
